### hw/rtl/skcpt_pkg.sv
package skcpt_pkg;

    localparam int FIELD_W     = 16;
    localparam int ID_BITS_DEF = 16;
    localparam int NUM_IN      = 12;
    localparam int NUM_OUT     = 8;
    localparam int IN_TDATA_W  = NUM_IN * FIELD_W;
    localparam int OUT_BITS    = 1 + (NUM_OUT - 1) * FIELD_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int NUM_RING    = 3;
    localparam int NUM_SPINDLE = 2;
    localparam int NUM_MEMBER  = NUM_RING + NUM_SPINDLE;
    localparam int REQ_SHARED  = 2;

    // input field slots in tdata, in units of FIELD_W
    localparam int SLOT_FIRST  = 0;
    localparam int SLOT_SECOND = 1;
    localparam int SLOT_A      = 2;
    localparam int SLOT_B      = SLOT_A + NUM_MEMBER;

    // output field offsets
    localparam int OFS_MATCH   = 0;
    localparam int OFS_COMMON  = 1;
    localparam int OFS_OSP_LO  = OFS_COMMON + FIELD_W;
    localparam int OFS_OSP_HI  = OFS_OSP_LO + FIELD_W;
    localparam int OFS_SHR_LO  = OFS_OSP_HI + FIELD_W;
    localparam int OFS_SHR_HI  = OFS_SHR_LO + FIELD_W;
    localparam int OFS_LNR_LO  = OFS_SHR_HI + FIELD_W;
    localparam int OFS_LNR_HI  = OFS_LNR_LO + FIELD_W;

endpackage

### hw/rtl/seven_k_cluster_pair_test_unit.sv
// Result path: the input register loads at the input transfer, and the result register
// loads from it when the output stage can advance (output empty or accepted).
// Throughput: one pair per cycle; a result waiting on the output does not stop the input
// while the input register can move on.
// Reset: i_rst_n synchronous, active low; clears both stage valid flags, payload is not reset.
module seven_k_cluster_pair_test_unit
    import skcpt_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // first_index, second_index, a_ring0..2, a_spindle0..1, b_ring0..2, b_spindle0..1
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // is_match, common_spindle, other_spindle_low/high, shared_ring_low/high,
    // lone_ring_low/high, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int W = (ID_BITS < FIELD_W) ? ID_BITS : FIELD_W;

    logic               r_v1;
    logic               r_v2;
    logic [FIELD_W-1:0] r_first;
    logic [FIELD_W-1:0] r_second;
    logic [W-1:0]       r_a [NUM_MEMBER];
    logic [W-1:0]       r_b [NUM_MEMBER];
    logic [OUT_TDATA_W-1:0] r_out;
    logic [OUT_TDATA_W-1:0] n_out;

    logic adv1;
    logic take_in;

    assign adv1            = !r_v2 || i_m_axis_tready;
    assign o_s_axis_tready = !r_v1 || adv1;
    assign take_in         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (adv1) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_first  <= i_s_axis_tdata[SLOT_FIRST*FIELD_W +: FIELD_W];
            r_second <= i_s_axis_tdata[SLOT_SECOND*FIELD_W +: FIELD_W];
            for (int k = 0; k < NUM_MEMBER; k++) begin
                r_a[k] <= i_s_axis_tdata[(SLOT_A+k)*FIELD_W +: W];
                r_b[k] <= i_s_axis_tdata[(SLOT_B+k)*FIELD_W +: W];
            end
        end
        if (adv1 && r_v1) begin
            r_out <= n_out;
        end
    end

    // compare network
    logic [NUM_SPINDLE-1:0][NUM_SPINDLE-1:0] sp_eq;
    logic [NUM_RING-1:0][NUM_RING-1:0]       rg_eq;
    logic [NUM_RING-1:0]                     rg_row;
    logic [W-1:0] scom, oa, ob, sh0, sh1, la, lb;
    logic         oa_in_b, ob_in_a, idx_ok, sp_ok, rg_ok, match;
    logic [W-1:0] osp_lo, osp_hi, shr_lo, shr_hi, lnr_lo, lnr_hi;

    always_comb begin
        for (int i = 0; i < NUM_SPINDLE; i++) begin
            for (int j = 0; j < NUM_SPINDLE; j++) begin
                sp_eq[i][j] = (r_a[NUM_RING+i] == r_b[NUM_RING+j]);
            end
        end
        for (int i = 0; i < NUM_RING; i++) begin
            for (int j = 0; j < NUM_RING; j++) begin
                rg_eq[i][j] = (r_a[i] == r_b[j]);
            end
            rg_row[i] = |rg_eq[i];
        end

        idx_ok = (r_second > r_first);
        sp_ok  = ($countones(sp_eq) == 1);
        rg_ok  = ($countones(rg_eq) == REQ_SHARED);

        scom = (|sp_eq[0]) ? r_a[NUM_RING] : r_a[NUM_RING+1];
        oa   = (r_a[NUM_RING] == scom) ? r_a[NUM_RING+1] : r_a[NUM_RING];
        ob   = (r_b[NUM_RING] == scom) ? r_b[NUM_RING+1] : r_b[NUM_RING];

        oa_in_b = 1'b0;
        ob_in_a = 1'b0;
        for (int k = 0; k < NUM_MEMBER; k++) begin
            oa_in_b = oa_in_b || (r_b[k] == oa);
            ob_in_a = ob_in_a || (r_a[k] == ob);
        end

        // first and second equal pairing in A-major order
        sh0 = rg_row[0] ? r_a[0] : (rg_row[1] ? r_a[1] : r_a[2]);
        sh1 = rg_row[2] ? r_a[2] : (rg_row[1] ? r_a[1] : r_a[0]);

        la = '0;
        for (int k = NUM_RING - 1; k >= 0; k--) begin
            if (r_a[k] != sh0 && r_a[k] != sh1) begin
                la = r_a[k];
            end
        end
        lb = '0;
        for (int k = NUM_RING - 1; k >= 0; k--) begin
            if (r_b[k] != sh0 && r_b[k] != sh1) begin
                lb = r_b[k];
            end
        end

        osp_lo = (oa < ob) ? oa : ob;
        osp_hi = (oa < ob) ? ob : oa;
        shr_lo = (sh0 < sh1) ? sh0 : sh1;
        shr_hi = (sh0 < sh1) ? sh1 : sh0;
        lnr_lo = (la < lb) ? la : lb;
        lnr_hi = (la < lb) ? lb : la;

        match = idx_ok && sp_ok && !oa_in_b && !ob_in_a && rg_ok;

        n_out = '0;
        if (match) begin
            n_out[OFS_MATCH]                = 1'b1;
            n_out[OFS_COMMON +: FIELD_W]    = FIELD_W'(scom);
            n_out[OFS_OSP_LO +: FIELD_W]    = FIELD_W'(osp_lo);
            n_out[OFS_OSP_HI +: FIELD_W]    = FIELD_W'(osp_hi);
            n_out[OFS_SHR_LO +: FIELD_W]    = FIELD_W'(shr_lo);
            n_out[OFS_SHR_HI +: FIELD_W]    = FIELD_W'(shr_hi);
            n_out[OFS_LNR_LO +: FIELD_W]    = FIELD_W'(lnr_lo);
            n_out[OFS_LNR_HI +: FIELD_W]    = FIELD_W'(lnr_hi);
        end
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = r_out;

endmodule

### hw/rtl/skcpt_checker.sv
module skcpt_checker
    import skcpt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    logic             m_match;
    logic [FIELD_W-1:0] m_com, m_osl, m_osh, m_srl, m_srh, m_lrl, m_lrh;

    assign m_match = o_m_axis_tdata[OFS_MATCH];
    assign m_com   = o_m_axis_tdata[OFS_COMMON +: FIELD_W];
    assign m_osl   = o_m_axis_tdata[OFS_OSP_LO +: FIELD_W];
    assign m_osh   = o_m_axis_tdata[OFS_OSP_HI +: FIELD_W];
    assign m_srl   = o_m_axis_tdata[OFS_SHR_LO +: FIELD_W];
    assign m_srh   = o_m_axis_tdata[OFS_SHR_HI +: FIELD_W];
    assign m_lrl   = o_m_axis_tdata[OFS_LNR_LO +: FIELD_W];
    assign m_lrh   = o_m_axis_tdata[OFS_LNR_HI +: FIELD_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |-> ##2 o_m_axis_tvalid)
        else $error("input transfer produced no result");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !m_match |-> o_m_axis_tdata == '0)
        else $error("non-match result carries data");

    a_pairs_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && m_match |-> m_osl <= m_osh && m_srl <= m_srh && m_lrl <= m_lrh)
        else $error("result pair not ascending");

    a_common_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && m_match |-> m_com != m_osl && m_com != m_osh)
        else $error("common spindle equals an unshared spindle");

endmodule

bind seven_k_cluster_pair_test_unit skcpt_checker u_skcpt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
